>>> src/pfe_pkg.sv
package pfe_pkg;

  // Data path width and variable table size
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned NUM_VARS = 26;
  localparam int unsigned VAR_AW   = $clog2(NUM_VARS);

  // Item kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EXPR = 1'b1;

  // Expression characters
  localparam logic [7:0] CH_A     = 8'h61;  // 'a'
  localparam logic [7:0] CH_Z     = 8'h7a;  // 'z'
  localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_MUL   = 8'h2a;  // '*'
  localparam logic [7:0] CH_DIV   = 8'h2f;  // '/'

  // Result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_e;

endpackage

>>> src/pfe_vars.sv
// Variable table: 26 x 32 memory, one write and one registered read port.
// Valid bits make never-written entries read as zero after reset.
module pfe_vars import pfe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [VAR_AW-1:0]        waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [VAR_AW-1:0]        raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0]   mem [NUM_VARS];
  logic [NUM_VARS-1:0] valid_q;
  logic [DATA_W-1:0]   rdata_q;

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/pfe_div.sv
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// Quotient truncates toward zero; sign is fixed up at the output.
module pfe_div import pfe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DATA_W-1:0]        dividend_i,
  input  logic [DATA_W-1:0]        divisor_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [DATA_W-1:0]        quotient_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, done_q, neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q, quo_q, den_q;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic              take;

  // one trial subtraction per step
  assign rem_sh  = {rem_q, quo_q[DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign take    = !rem_sub[DATA_W];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // data path
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[DATA_W-1] ? (DATA_W'(0) - dividend_i) : dividend_i;
      den_q <= divisor_i[DATA_W-1]  ? (DATA_W'(0) - divisor_i)  : divisor_i;
      rem_q <= '0;
      neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (busy_q) begin
      rem_q <= take ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], take};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

>>> src/postfix_expression_evaluator_unit.sv
// Postfix expression evaluator. Each input beat is either a variable load
// (op = 0, writes one of 26 registers if its index is below 26) or one
// expression character (op = 1). Letters push a variable, + - * / pop two
// and push the 32-bit wrapped result, other characters are ignored. The
// expression beat marked last produces one output beat with the top of
// stack and a sticky status, then the stack is emptied. A division waits
// for the one-bit-per-cycle divider, and the last beat for the output
// register to be free. The stack is a synchronous memory with its top
// held in a register, so each operator needs a single memory read; items
// are processed one at a time, so memory accesses never overlap. Stack
// overflow, underflow and divide by zero are reported in status, and
// result is zero whenever status is not ok.
module postfix_expression_evaluator_unit import pfe_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     op_i,
  input  logic [4:0]               var_index_i,
  input  logic signed [31:0]       var_value_i,
  input  logic [7:0]               symbol_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [31:0]       result_o,
  output logic [1:0]               status_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  status_e           err_q, err_d;
  logic [DATA_W-1:0] tos_q, tos_d;
  logic [7:0]        sym_q;
  logic              last_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] result_q;
  status_e           status_q;

  logic              in_acc;
  logic              out_free;
  logic              is_letter, is_oper;
  logic [DATA_W-1:0] var_rdata;
  logic [DATA_W-1:0] stk_rdata_q;
  logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
  logic              stk_we, stk_re;
  logic [AW-1:0]     stk_waddr, stk_raddr;
  logic [DATA_W-1:0] mul_res;
  logic              div_start, div_busy, div_done;
  logic [DATA_W-1:0] div_quo;
  logic              end_load;
  status_e           end_status;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // character class of the current item
  assign is_letter = (sym_q >= CH_A) && (sym_q <= CH_Z);
  assign is_oper   = (sym_q == CH_PLUS) || (sym_q == CH_MINUS) ||
                     (sym_q == CH_MUL)  || (sym_q == CH_DIV);

  // variable table
  pfe_vars u_vars (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (in_acc && (op_i == OP_LOAD) && (var_index_i < 5'(NUM_VARS))),
    .waddr_i (var_index_i[VAR_AW-1:0]),
    .wdata_i (var_value_i),
    .re_i    (in_acc && (op_i == OP_EXPR)),
    .raddr_i (VAR_AW'(symbol_i - CH_A)),
    .rdata_o (var_rdata)
  );

  // operand stack below the top; top lives in tos_q
  assign stk_re    = in_acc && (op_i == OP_EXPR);
  assign stk_raddr = AW'(count_q - CW'(2));
  assign stk_waddr = AW'(count_q - CW'(1));

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= tos_q;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  // low word of the product, registered into the top of stack
  assign mul_res = DATA_W'(stk_rdata_q * tos_q);

  pfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (stk_rdata_q),
    .divisor_i  (tos_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // end-of-expression status
  always_comb begin
    end_status = err_q;
    if (err_q == ST_OK && count_q == '0) begin
      end_status = ST_UNDERFLOW;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    err_d     = err_q;
    tos_d     = tos_q;
    stk_we    = 1'b0;
    div_start = 1'b0;
    end_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && op_i == OP_EXPR) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_END;
        if (is_letter) begin
          if (count_q == CW'(STACK_DEPTH)) begin
            if (err_q == ST_OK) err_d = ST_OVERFLOW;
          end else begin
            stk_we  = (count_q != '0);
            tos_d   = var_rdata;
            count_d = count_q + 1'b1;
          end
        end else if (is_oper) begin
          if (count_q < CW'(2)) begin
            if (err_q == ST_OK) err_d = ST_UNDERFLOW;
          end else if (sym_q == CH_PLUS) begin
            tos_d   = stk_rdata_q + tos_q;
            count_d = count_q - 1'b1;
          end else if (sym_q == CH_MINUS) begin
            tos_d   = stk_rdata_q - tos_q;
            count_d = count_q - 1'b1;
          end else if (sym_q == CH_MUL) begin
            tos_d   = mul_res;
            count_d = count_q - 1'b1;
          end else if (tos_q == '0) begin
            if (err_q == ST_OK) err_d = ST_DIVZERO;
            tos_d   = '0;
            count_d = count_q - 1'b1;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          tos_d   = div_quo;
          count_d = count_q - 1'b1;
          state_d = S_END;
        end
      end
      S_END: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          end_load = 1'b1;
          count_d  = '0;
          err_d    = ST_OK;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      err_q   <= err_d;
      if (end_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    if (in_acc) begin
      sym_q  <= symbol_i;
      last_q <= last_i;
    end
    if (end_load) begin
      result_q <= (end_status == ST_OK) ? tos_q : '0;
      status_q <= end_status;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign status_o    = status_q;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_err_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (result_o == '0))
    else $error("nonzero result with error status");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_DIV))
    else $error("divider running outside division");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_i == OP_LOAD) |=> !in_stall_o)
    else $error("load beat did not complete in one cycle");

endmodule

>>> tb/postfix_expression_evaluator_unit_tb.sv
module postfix_expression_evaluator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfe_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int RESET_CYCLES = 12;
  localparam int LIVE_BEATS = 1250;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 60;
  localparam logic [31:0] INT_MAX = 32'h7fffffff;
  localparam logic [31:0] INT_MIN = 32'h80000000;
  localparam logic [31:0] MINUS_ONE = 32'hffffffff;

  typedef struct {
    logic        op;
    logic [4:0]  idx;
    logic [31:0] val;
    logic [7:0]  sym;
    logic        last;
  } beat_t;

  typedef struct {
    logic [31:0] res;
    status_e     st;
  } outcome_t;

  typedef struct {
    beat_t    b;
    bit       typed;
    outcome_t want;
  } row_t;

  // DUT connections
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = 1'b0;
  logic [4:0]         var_index = '0;
  logic signed [31:0] var_value = '0;
  logic [7:0]         symbol = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] result;
  logic [1:0]         status;

  // Evaluator shadow state
  logic [31:0] var_tab [NUM_VARS];
  logic [31:0] opnd [STACK_DEPTH];
  int          depth = 0;
  status_e     sticky = ST_OK;

  outcome_t want_q [$];
  row_t     plan [$];
  int       errors = 0;
  int       live_beats = 0;
  bit       no_idle = 1'b0;
  bit       hold_req = 1'b0;

  postfix_expression_evaluator_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .op_i       (op),
    .var_index_i(var_index),
    .var_value_i(var_value),
    .symbol_i   (symbol),
    .last_i     (last),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .result_o   (result),
    .status_o   (status)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic bit is_letter(logic [7:0] s);
    return s >= CH_A && s <= CH_Z;
  endfunction

  function automatic bit is_oper(logic [7:0] s);
    return s == CH_PLUS || s == CH_MINUS || s == CH_MUL || s == CH_DIV;
  endfunction

  // first error of an expression wins
  function automatic void note_error(status_e code);
    if (sticky == ST_OK) sticky = code;
  endfunction

  function automatic void push_opnd(logic [31:0] v);
    if (depth >= STACK_DEPTH) begin
      note_error(ST_OVERFLOW);
    end else begin
      opnd[depth] = v;
      depth++;
    end
  endfunction

  // signed division rounding toward zero, INT_MIN / -1 wraps
  function automatic logic [31:0] quot_trunc(logic [31:0] x, logic [31:0] y);
    logic [31:0] mx, my, q;
    mx = x[31] ? -x : x;
    my = y[31] ? -y : y;
    q = mx / my;
    return (x[31] ^ y[31]) ? -q : q;
  endfunction

  // Advance the shadow evaluator by one beat; returns 1 when a result is due
  function automatic bit eval_beat(beat_t b, output outcome_t o);
    logic [31:0] x, y, r;
    o.res = '0;
    o.st = ST_OK;
    if (b.op == OP_LOAD) begin
      if (b.idx < NUM_VARS) var_tab[b.idx] = b.val;
      return 1'b0;
    end
    if (is_letter(b.sym)) begin
      push_opnd(var_tab[b.sym - CH_A]);
    end else if (is_oper(b.sym)) begin
      if (depth < 2) begin
        note_error(ST_UNDERFLOW);
      end else begin
        y = opnd[depth-1];
        x = opnd[depth-2];
        depth -= 2;
        case (b.sym)
          CH_PLUS:  r = x + y;
          CH_MINUS: r = x - y;
          CH_MUL:   r = x * y;
          default: begin
            if (y == '0) begin
              note_error(ST_DIVZERO);
              r = '0;
            end else begin
              r = quot_trunc(x, y);
            end
          end
        endcase
        push_opnd(r);
      end
    end
    if (!b.last) return 1'b0;
    if (depth == 0) note_error(ST_UNDERFLOW);
    else o.res = opnd[depth-1];
    if (sticky != ST_OK) o.res = '0;
    o.st = sticky;
    depth = 0;
    sticky = ST_OK;
    return 1'b1;
  endfunction

  // Offer one input beat after a random gap and record what it should produce
  task automatic send_beat(beat_t b, bit typed, outcome_t want);
    int       gap;
    outcome_t o;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    op        <= b.op;
    var_index <= b.idx;
    var_value <= b.val;
    symbol    <= b.sym;
    last      <= b.last;
    do @(posedge clk); while (in_stall);
    if (b.op == OP_LOAD ? b.idx < NUM_VARS : (is_letter(b.sym) || is_oper(b.sym) || b.last))
      live_beats++;
    if (eval_beat(b, o)) want_q.push_back(typed ? want : o);
  endtask

  function automatic void tab(logic o, logic [4:0] i, logic [31:0] v, logic [7:0] s,
                              logic l, bit typed = 1'b0, logic [31:0] res = '0,
                              status_e st = ST_OK);
    row_t r;
    r.b = '{op: o, idx: i, val: v, sym: s, last: l};
    r.typed = typed;
    r.want = '{res: res, st: st};
    plan.push_back(r);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'd1;
      2: return MINUS_ONE;
      3: return INT_MIN;
      4: return INT_MAX;
      5: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_oper();
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] s;
    do s = $urandom_range(0, 255); while (is_letter(s) || is_oper(s));
    return s;
  endfunction

  function automatic beat_t char_beat(logic [7:0] s);
    beat_t b;
    b = '{op: OP_EXPR, idx: $urandom_range(0, 31), val: $urandom, sym: s, last: 1'b0};
    return b;
  endfunction

  function automatic beat_t load_beat();
    beat_t b;
    b.op = OP_LOAD;
    b.idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 25);
    b.val = pick_value();
    b.sym = $urandom_range(0, 255);
    b.last = $urandom_range(0, 1);
    return b;
  endfunction

  // One expression: mostly well formed, some broken, overflowing or pure noise
  task automatic run_expression();
    beat_t    seq [$];
    beat_t    b;
    outcome_t none;
    int       kind, n_chars, d, k;
    none = '{res: '0, st: ST_OK};
    kind = $urandom_range(0, 39);
    repeat ($urandom_range(0, 3)) seq.push_back(load_beat());
    if (kind == 0) begin
      repeat (STACK_DEPTH + $urandom_range(1, 3))
        seq.push_back(char_beat(CH_A + $urandom_range(0, 25)));
      seq.push_back(char_beat(pick_oper()));
    end else if (kind < 4) begin
      repeat ($urandom_range(1, 6)) begin
        b = '{op: $urandom_range(0, 1), idx: $urandom_range(0, 31), val: $urandom,
              sym: $urandom_range(0, 255), last: $urandom_range(0, 1)};
        seq.push_back(b);
      end
    end else begin
      n_chars = $urandom_range(1, 12);
      d = 0;
      // underflow right at the start
      if (kind < 7) seq.push_back(char_beat(pick_oper()));
      // kinds 4 to 8 may stop with values left below the top
      for (k = 0; k < n_chars || (d > 1 && kind >= 9); k++) begin
        if (d >= 2 && (k >= n_chars || $urandom_range(0, 1))) begin
          seq.push_back(char_beat(pick_oper()));
          d--;
        end else begin
          seq.push_back(char_beat(CH_A + $urandom_range(0, 25)));
          d++;
        end
        if ($urandom_range(0, 15) == 0)
          seq.push_back($urandom_range(0, 1) ? load_beat() : char_beat(pick_junk()));
      end
    end
    // close the expression, except now and then with a load beat
    if (seq[$].op == OP_EXPR || $urandom_range(0, 3) != 0) begin
      seq[$].op = OP_EXPR;
      seq[$].last = 1'b1;
    end
    foreach (seq[i]) send_beat(seq[i], 1'b0, none);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin : check_out
      outcome_t w;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected beat result=%0d status=%0d", $time, result, status);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (result !== w.res) begin
          $display("%0t: result expected %0d actual %0d", $time, $signed(w.res), result);
          errors++;
        end
        if (status !== w.st) begin
          $display("%0t: status expected %0d actual %0d", $time, w.st, status);
          errors++;
        end
      end
    end
  end

  // Output side: random stalls, one long hold-off on request
  initial begin : drain
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus
  initial begin : stim
    outcome_t none;
    bit       hold_done;
    none = '{res: '0, st: ST_OK};
    hold_done = 1'b0;
    foreach (var_tab[i]) var_tab[i] = '0;
    foreach (opnd[i]) opnd[i] = '0;

    // reset values, empty stack, extremes, wraps and error codes
    tab(OP_EXPR, 0, 0, CH_A, 1, 1, '0, ST_OK);
    tab(OP_EXPR, 0, 0, 8'h00, 1, 1, '0, ST_UNDERFLOW);
    tab(OP_LOAD, 0, INT_MAX, 8'h00, 0);
    tab(OP_LOAD, 1, INT_MIN, 8'hff, 1);
    tab(OP_LOAD, 31, 32'h12345678, 8'h00, 0);
    tab(OP_LOAD, 25, MINUS_ONE, 8'h00, 0);
    tab(OP_EXPR, 0, 0, CH_A, 0);
    tab(OP_EXPR, 0, 0, CH_A + 1, 0);
    tab(OP_EXPR, 0, 0, CH_PLUS, 1, 1, MINUS_ONE, ST_OK);
    tab(OP_EXPR, 0, 0, CH_A + 1, 0);
    tab(OP_EXPR, 0, 0, CH_Z, 0);
    tab(OP_EXPR, 0, 0, CH_DIV, 1, 1, INT_MIN, ST_OK);
    tab(OP_EXPR, 0, 0, CH_A, 0);
    tab(OP_EXPR, 0, 0, CH_Z - 1, 0);
    tab(OP_EXPR, 0, 0, CH_DIV, 1, 1, '0, ST_DIVZERO);
    tab(OP_EXPR, 0, 0, CH_A, 0);
    tab(OP_EXPR, 0, 0, CH_A, 0);
    tab(OP_EXPR, 0, 0, CH_MUL, 1, 1, 32'd1, ST_OK);
    tab(OP_EXPR, 0, 0, CH_Z, 0);
    tab(OP_EXPR, 0, 0, CH_A, 0);
    tab(OP_EXPR, 0, 0, CH_MINUS, 0);
    tab(OP_EXPR, 31, MINUS_ONE, 8'hff, 1, 1, INT_MIN, ST_OK);
    tab(OP_EXPR, 0, 0, CH_A, 0);
    tab(OP_EXPR, 0, 0, CH_MINUS, 0);
    tab(OP_EXPR, 0, 0, CH_Z, 0);
    tab(OP_EXPR, 0, 0, CH_PLUS, 1, 1, '0, ST_UNDERFLOW);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) send_beat(plan[i].b, plan[i].typed, plan[i].want);

    // fill the variable table, then random expressions
    for (int i = 0; i < NUM_VARS; i++)
      send_beat('{op: OP_LOAD, idx: i, val: pick_value(), sym: $urandom_range(0, 255),
                  last: 1'b0}, 1'b0, none);
    live_beats = 0;
    while (live_beats < LIVE_BEATS) begin
      if ($urandom_range(0, 24) == 0) no_idle = !no_idle;
      if (!hold_done && live_beats >= LIVE_BEATS / 2) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      run_expression();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (want_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
